// ===== rtl/aes_block_encrypt_macros.svh =====
// assertion macros for the aes block encrypt checker
// no dependencies
`ifndef AES_BLOCK_ENCRYPT_MACROS_SVH
`define AES_BLOCK_ENCRYPT_MACROS_SVH
// implication checked on every clock, idle during reset
`define AES_ASSERT_IMP(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);
// implication checked also during reset
`define AES_ASSERT_ALWAYS(label, clk, lhs, rhs, msg) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== rtl/aesenc_pkg.sv =====
// aes encryption package: s-box table and round functions
// no dependencies
package aesenc_pkg;

    localparam int BLOCK_W = 128;
    localparam int MAX_ROUNDS = 14;
    localparam int MAX_WORDS = 60;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [31:0] word_t;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte n of the state sits at bits [127-8n -: 8]
    function automatic block_t aes_round(input block_t st, input block_t rk,
                                         input logic last);
        logic [7:0] sb [16];
        logic [7:0] tm [16];
        logic [7:0] a0, a1, a2, a3;
        block_t res;
        for (int n = 0; n < 16; n++) begin
            sb[n] = SBOX[st[127-8*n -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                tm[4*c+r] = sb[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = tm[4*c];
            a1 = tm[4*c+1];
            a2 = tm[4*c+2];
            a3 = tm[4*c+3];
            if (last) begin
                res[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                res[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                       xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        aes_round = res ^ rk;
    endfunction

endpackage

// ===== rtl/aes_block_encrypt.sv =====
// aes block encrypt top level: key schedule sequencer and 15-stage round pipeline
// depends on aesenc_pkg
//
// channel   dir  fields (low bit up)
// s_        in   tdata: plain_high[63:0], plain_low[127:64]
// m_        out  tdata: cipher_high[63:0], cipher_low[127:64]
// cfg_      in   index 0 mode, 1..4 key words
//
// one block per cycle unless m_tready stalls or the key schedule is being built; initial key add plus 14 round stages
// the key schedule is built after reset and after any config write: a load state, then
// an expand state that writes the expanded words one after another; s_tready low meanwhile
// a stall on m_tready freezes the whole pipeline, nothing lost or repeated
module aes_block_encrypt
    import aesenc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plain_high[63:0], plain_low[127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_high[63:0], cipher_low[127:64]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_EXPAND} ks_state_t;

    ks_state_t   state_reg;
    logic [1:0]  mode_reg;
    logic [63:0] key_reg [4];
    word_t       rk_reg [MAX_WORDS];
    word_t       win_reg [8];
    logic [5:0]  idx_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  rcon_reg;

    logic [1:0]  mode_eff;
    logic [2:0]  nk;
    logic [3:0]  nr;
    logic [5:0]  last_idx;
    word_t       kw [8];
    word_t       t_word, new_word, old_word;

    assign mode_eff = (mode_reg == 2'd3) ? MODE_256 : mode_reg;
    always_comb begin
        case (mode_eff)
            MODE_192: begin nk = 3'd6; nr = 4'd12; last_idx = 6'd51; old_word = win_reg[5]; end
            MODE_256: begin nk = 3'd0; nr = 4'd14; last_idx = 6'd59; old_word = win_reg[7]; end
            default:  begin nk = 3'd4; nr = 4'd10; last_idx = 6'd43; old_word = win_reg[3]; end
        endcase
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            kw[j] = key_reg[j/2][63-32*(j%2) -: 32];
        end
    end

    // nk of 8 is held as zero in three bits
    always_comb begin
        if (phase_reg == 3'd0) begin
            t_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end else if (mode_eff == MODE_256 && phase_reg == 3'd4) begin
            t_word = sub_word(win_reg[0]);
        end else begin
            t_word = win_reg[0];
        end
        new_word = old_word ^ t_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            mode_reg  <= MODE_128;
            for (int j = 0; j < 4; j++) key_reg[j] <= '0;
        end else begin
            if (cfg_wr_en) begin
                state_reg <= ST_LOAD;
                case (cfg_index)
                    REG_MODE: mode_reg   <= cfg_wdata[1:0];
                    REG_KEY0: key_reg[0] <= cfg_wdata;
                    REG_KEY1: key_reg[1] <= cfg_wdata;
                    REG_KEY2: key_reg[2] <= cfg_wdata;
                    REG_KEY3: key_reg[3] <= cfg_wdata;
                    default: ;
                endcase
            end else begin
                unique case (state_reg)
                    ST_LOAD: begin
                        for (int j = 0; j < 8; j++) rk_reg[j] <= kw[j];
                        for (int j = 0; j < 8; j++) begin
                            win_reg[j] <= kw[(int'(nk) + 7 - j) % 8];
                        end
                        idx_reg   <= {3'd0, nk} + ((nk == 3'd0) ? 6'd8 : 6'd0);
                        phase_reg <= 3'd0;
                        rcon_reg  <= 8'h01;
                        state_reg <= ST_EXPAND;
                    end
                    ST_EXPAND: begin
                        rk_reg[idx_reg] <= new_word;
                        for (int j = 1; j < 8; j++) win_reg[j] <= win_reg[j-1];
                        win_reg[0] <= new_word;
                        idx_reg    <= idx_reg + 6'd1;
                        phase_reg  <= (phase_reg + 3'd1 == nk) ? 3'd0 : phase_reg + 3'd1;
                        if (phase_reg == 3'd0) rcon_reg <= xtime(rcon_reg);
                        if (idx_reg == last_idx) state_reg <= ST_IDLE;
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    // round pipeline
    logic   vld_reg [MAX_ROUNDS+1];
    block_t dat_reg [MAX_ROUNDS+1];
    logic   en;

    assign en       = !vld_reg[MAX_ROUNDS] || m_tready;
    assign s_tready = en && (state_reg == ST_IDLE);
    assign m_tvalid = vld_reg[MAX_ROUNDS];
    assign m_tdata  = {dat_reg[MAX_ROUNDS][63:0], dat_reg[MAX_ROUNDS][127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid && s_tready;
        end
        if (en) begin
            dat_reg[0] <= {s_tdata[63:0], s_tdata[127:64]}
                          ^ {rk_reg[0], rk_reg[1], rk_reg[2], rk_reg[3]};
        end
    end

    for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[r] <= 1'b0;
            end else if (en) begin
                vld_reg[r] <= vld_reg[r-1];
            end
            if (en) begin
                if (4'(r) <= nr) begin
                    dat_reg[r] <= aes_round(dat_reg[r-1],
                        {rk_reg[4*r], rk_reg[4*r+1], rk_reg[4*r+2], rk_reg[4*r+3]},
                        4'(r) == nr);
                end else begin
                    dat_reg[r] <= dat_reg[r-1];
                end
            end
        end
    end

endmodule

// ===== rtl/aesenc_checker.sv =====
// port-level checker for aes_block_encrypt, bound to the top level
// depends on aes_block_encrypt_macros.svh
`include "aes_block_encrypt_macros.svh"
module aesenc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_wr_en
);
    // key schedule rebuild blocks input after reset and after a write
    `AES_ASSERT_ALWAYS(a_reset_blocks, aclk, !aresetn, !s_tready, "input open right after reset")
    `AES_ASSERT_IMP(a_cfg_blocks, aclk, aresetn, cfg_wr_en, !s_tready, "input open after config write")
    `AES_ASSERT_IMP(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule

bind aes_block_encrypt aesenc_checker u_aesenc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .cfg_wr_en(cfg_wr_en)
);

// ===== verif/testbench.sv =====
// self-checking bench for aes_block_encrypt: streams plaintext blocks under several keys
// and compares every ciphertext with an in-bench aes model; depends on aesenc_pkg and the rtl
module testbench;
    import aesenc_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;    // plain_high[63:0], plain_low[127:64]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // cipher_high[63:0], cipher_low[127:64]
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = REG_MODE;
    logic [63:0]  cfg_wdata = '0;

    aes_block_encrypt dut (.*);

    logic [127:0] plain_q [$];
    logic [127:0] cipher_q [$];
    logic [7:0]   sbox_tab [256];
    logic [1:0]   mode_sh = MODE_128;
    logic [63:0]  key_sh [4] = '{default: '0};
    logic         calm = 1'b0;
    logic         s_took = 1'b0;
    int           errors = 0;
    int           blocks_done = 0;
    int           key_loads = 0;
    int           cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // inverse as a^254, then the affine map
    function automatic logic [7:0] sbox_calc(input logic [7:0] a);
        logic [7:0] t, inv, s;
        t = a;
        inv = 8'h01;
        for (int i = 1; i < 8; i++) begin
            t = gmul(t, t);
            inv = gmul(inv, t);
        end
        s = inv ^ 8'h63;
        for (int k = 1; k < 5; k++) s ^= 8'(({inv, inv} >> (8 - k)));
        return s;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] x);
        return {sbox_tab[x[31:24]], sbox_tab[x[23:16]], sbox_tab[x[15:8]], sbox_tab[x[7:0]]};
    endfunction

    function automatic logic [127:0] aes_cipher(input logic [127:0] blk);
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  st [16];
        logic [7:0]  tm [16];
        logic [7:0]  rc, a0, a1, a2, a3;
        logic [63:0] hi, lo;
        int          md, nk, nr;
        md = (mode_sh > MODE_256) ? 2 : int'(mode_sh);
        nk = 4 + 2 * md;
        nr = nk + 6;
        for (int i = 0; i < nk; i++) w[i] = key_sh[i / 2][63 - 32 * (i % 2) -: 32];
        rc = 8'h01;
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            st[i] = blk[63 - 8 * i -: 8];
            st[8 + i] = blk[127 - 8 * i -: 8];
        end
        for (int rnd = 0; rnd <= nr; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tm[4 * c + r] = sbox_tab[st[4 * ((c + r) % 4) + r]];
                for (int c = 0; c < 4; c++) begin
                    a0 = tm[4 * c];
                    a1 = tm[4 * c + 1];
                    a2 = tm[4 * c + 2];
                    a3 = tm[4 * c + 3];
                    if (rnd == nr) begin
                        st[4 * c] = a0; st[4 * c + 1] = a1;
                        st[4 * c + 2] = a2; st[4 * c + 3] = a3;
                    end else begin
                        st[4 * c]     = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                        st[4 * c + 1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                        st[4 * c + 2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                        st[4 * c + 3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4 * c + r] ^= w[rnd * 4 + c][31 - 8 * r -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            hi[63 - 8 * i -: 8] = st[i];
            lo[63 - 8 * i -: 8] = st[8 + i];
        end
        return {lo, hi};
    endfunction

    // input side: hold the block until its transfer, otherwise maybe idle
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (plain_q.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                s_tvalid <= 1'b1;
                s_tdata <= plain_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && (calm || $urandom_range(99) >= 34);
    end

    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            void'(plain_q.pop_front());
            cipher_q.insert(cipher_q.size(), aes_cipher(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_q.size() == 0) begin
                $error("ciphertext transfer with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                if (m_tdata[63:0] !== cipher_q[0][63:0]) begin
                    $error("cipher_high expected %h actual %h", cipher_q[0][63:0], m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== cipher_q[0][127:64]) begin
                    $error("cipher_low expected %h actual %h",
                           cipher_q[0][127:64], m_tdata[127:64]);
                    errors++;
                end
                void'(cipher_q.pop_front());
                blocks_done++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 300000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_MODE) mode_sh = val[1:0];
        else if (idx <= REG_KEY3) key_sh[2'(idx - REG_KEY0)] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_key(input logic [1:0] md, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        reg_write(REG_MODE, {62'h0, md});
        reg_write(REG_KEY0, k0);
        reg_write(REG_KEY1, k1);
        reg_write(REG_KEY2, k2);
        reg_write(REG_KEY3, k3);
        key_loads++;
    endtask

    task automatic wait_empty();
        while (plain_q.size() != 0 || cipher_q.size() != 0) @(posedge aclk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (25) @(posedge aclk);
    endtask

    task automatic add_block(input logic [127:0] blk);
        plain_q.insert(plain_q.size(), blk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) add_block({rand64(), rand64()});
    endtask

    initial begin
        logic [63:0] kx [4];
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(8'(i));
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all-zero key after reset, extreme and textbook plaintexts
        add_block('0);
        add_block('1);
        add_block({64'h8899aabbccddeeff, 64'h0011223344556677});
        add_block({64'h0, 64'h8000000000000000});
        add_block({64'h1, 64'h0});
        add_block({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        drain();
        load_key(MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        add_block({64'h8899aabbccddeeff, 64'h0011223344556677});
        add_block('1);
        drain();
        load_key(MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        add_block({64'h8899aabbccddeeff, 64'h0011223344556677});
        add_block('0);
        drain();
        load_key(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        add_block({64'h8899aabbccddeeff, 64'h0011223344556677});
        add_block('1);
        drain();
        // mode three behaves as a 256-bit key, with an all-ones key
        load_key(MODE_256 + 2'd1, '1, '1, '1, '1);
        add_block('0);
        add_block('1);
        drain();
        // writes to indexes past the last key register are dropped
        for (int k = 1; k <= 3; k++) reg_write(REG_KEY3 + 3'(k), '1);
        add_block({64'h0123456789abcdef, 64'hfedcba9876543210});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int j = 0; j < 4; j++) kx[j] = rand64();
            load_key(2'($urandom_range(3)), kx[0], kx[1], kx[2], kx[3]);
            calm = (ph == 3);
            push_random(120);
            if (ph == 5) begin
                // sender holds off until the pipeline is empty
                wait_empty();
            end
            push_random(130);
            drain();
        end
        calm = 1'b0;

        $display("%0d blocks encrypted under %0d key loads, all key lengths and mode three",
                 blocks_done, key_loads);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/aesenc_pkg.sv
rtl/aes_block_encrypt.sv
rtl/aesenc_checker.sv
verif/testbench.sv
